[design/ftr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ftr_pkg: frame transaction reassembler package
// Shared constants, status codes and beat payload types.
// ----------------------------------------------------------------------------
package ftr_pkg;

  localparam int unsigned MAX_TRANSACTION_BYTES = 8192;
  localparam int unsigned MAX_FRAME_WORDS       = 256;

  localparam logic [31:0] SIZE_LIMIT      = 32'(MAX_TRANSACTION_BYTES);
  localparam logic [8:0]  FRAME_WORDS_MAX = 9'(MAX_FRAME_WORDS);
  localparam logic [15:0] PAD_WORD        = 16'haaaa;
  localparam logic [8:0]  STOP_FRAME_LEN  = 9'd3;

  localparam int unsigned INDEX_W = 14;
  localparam int unsigned ADDR_W  = 13;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_SKIPPED       = 4'd1,
    ST_COMPLETED     = 4'd2,
    ST_AFTER_DONE    = 4'd3,
    ST_SECOND_START  = 4'd4,
    ST_BAD_TRANS     = 4'd5,
    ST_BAD_FRAME     = 4'd6,
    ST_TOO_LONG      = 4'd7,
    ST_BAD_PAD       = 4'd8,
    ST_BAD_LENGTH    = 4'd9,
    ST_NO_STOP       = 4'd10,
    ST_EARLY_STOP    = 4'd11,
    ST_IN_ERROR      = 4'd12
  } status_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] payload_word;
    logic [7:0]  word_position;
    logic [8:0]  frame_word_count;
    logic        start_flag;
    logic        stop_flag;
    logic [15:0] frame_transaction;
    logic [15:0] frame_sequence;
  } item_t;

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] write_address;
    logic [15:0]       write_data;
    status_t           status;
    logic [31:0]       transaction_bytes;
  } result_t;

  typedef struct packed {
    logic error;
    logic done;
  } flags_t;

endpackage
`default_nettype wire

[design/ftr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ftr_if: reassembler channel interfaces
// Valid/ready channels for payload beats and result beats.
// ----------------------------------------------------------------------------
interface ftr_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] payload_word;
  logic [7:0]  word_position;
  logic [8:0]  frame_word_count;
  logic        start_flag;
  logic        stop_flag;
  logic [15:0] frame_transaction;
  logic [15:0] frame_sequence;

  modport source (
    output valid, operation, payload_word, word_position, frame_word_count,
           start_flag, stop_flag, frame_transaction, frame_sequence,
    input  ready
  );
  modport sink (
    input  valid, operation, payload_word, word_position, frame_word_count,
           start_flag, stop_flag, frame_transaction, frame_sequence,
    output ready
  );
endinterface

interface ftr_out_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [12:0] write_address;
  logic [15:0] write_data;
  logic [3:0]  status;
  logic [31:0] transaction_bytes;

  modport source (
    output valid, write_valid, write_address, write_data, status, transaction_bytes,
    input  ready
  );
  modport sink (
    input  valid, write_valid, write_address, write_data, status, transaction_bytes,
    output ready
  );
endinterface
`default_nettype wire

[design/ftr_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ftr_core: reassembly state and frame checks
// Holds the transaction state, checks one beat and forms its result.
// ----------------------------------------------------------------------------
module ftr_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           advance,
  input  wire ftr_pkg::item_t item,
  output ftr_pkg::result_t    result,
  output ftr_pkg::flags_t     flags
);

  logic [ftr_pkg::INDEX_W-1:0] wi_r, wi_nxt;
  logic [31:0]                 size_r, size_nxt;
  logic [15:0]                 latched_r, latched_nxt;
  logic [15:0]                 expected_r, expected_nxt;
  logic                        done_r, done_nxt;
  logic                        err_r, err_nxt;
  logic                        skip_r, skip_nxt;
  logic [8:0]                  allowed_r, allowed_nxt;

  logic [8:0]                  n_c;
  logic                        started;
  logic                        in_start;
  logic [30:0]                 half;
  logic [30:0]                 wi_ext;
  logic [30:0]                 left;
  ftr_pkg::status_t            st;
  logic                        wv;
  logic [ftr_pkg::ADDR_W-1:0]  wa;
  logic [15:0]                 wd;

  assign n_c      = (item.frame_word_count > ftr_pkg::FRAME_WORDS_MAX) ?
                    ftr_pkg::FRAME_WORDS_MAX : item.frame_word_count;
  assign started  = (wi_r != '0);
  assign in_start = (expected_r == 16'd0);
  assign half     = size_r[31:1];
  assign wi_ext   = {17'd0, wi_r};
  assign left     = (wi_ext > half) ? 31'd0 : (half - wi_ext);

  always_comb begin
    wi_nxt       = wi_r;
    size_nxt     = size_r;
    latched_nxt  = latched_r;
    expected_nxt = expected_r;
    done_nxt     = done_r;
    err_nxt      = err_r;
    skip_nxt     = skip_r;
    allowed_nxt  = allowed_r;
    st           = ftr_pkg::ST_OK;
    wv           = 1'b0;
    wa           = '0;
    wd           = '0;

    if (item.operation) begin
      wi_nxt       = '0;
      size_nxt     = '0;
      latched_nxt  = '0;
      expected_nxt = '0;
      done_nxt     = 1'b0;
      err_nxt      = 1'b0;
      skip_nxt     = 1'b0;
      allowed_nxt  = '0;
    end else if (err_r) begin
      st = ftr_pkg::ST_IN_ERROR;
    end else if (done_r) begin
      st = ftr_pkg::ST_AFTER_DONE;
    end else begin
      // frame header checks at the first word
      if ({1'b0, item.word_position} >= n_c) begin
        st = ftr_pkg::ST_SKIPPED;
      end else if (item.word_position == 8'd0) begin
        if (!started && !item.start_flag) begin
          skip_nxt = 1'b1;
          st       = ftr_pkg::ST_SKIPPED;
        end else begin
          skip_nxt = 1'b0;
          if (started && item.start_flag) begin
            st = ftr_pkg::ST_SECOND_START;
          end else if (!started) begin
            latched_nxt = item.frame_transaction;
            allowed_nxt = n_c;
          end else if (item.frame_transaction != latched_r) begin
            st = ftr_pkg::ST_BAD_TRANS;
          end else if (item.frame_sequence != expected_r) begin
            st = ftr_pkg::ST_BAD_FRAME;
          end else if ({22'd0, n_c} > left) begin
            // short stop frame may end in padding
            if (item.stop_flag && (n_c == ftr_pkg::STOP_FRAME_LEN) && (left != 31'd0)) begin
              allowed_nxt = left[8:0];
            end else begin
              st = ftr_pkg::ST_TOO_LONG;
            end
          end else begin
            allowed_nxt = n_c;
          end
        end
      end else if (skip_r || !started) begin
        st = ftr_pkg::ST_SKIPPED;
      end

      if (st == ftr_pkg::ST_OK) begin
        if ({1'b0, item.word_position} < allowed_nxt) begin
          wv     = 1'b1;
          wa     = wi_r[ftr_pkg::ADDR_W-1:0] ^ 13'd1;
          wd     = item.payload_word;
          wi_nxt = wi_r + 14'd1;
          if (in_start && (item.word_position == 8'd0)) begin
            size_nxt = {item.payload_word, 16'd0};
          end else if (in_start && (item.word_position == 8'd1)) begin
            size_nxt = {size_r[31:16], item.payload_word};
          end
        end else if (item.payload_word != ftr_pkg::PAD_WORD) begin
          st = ftr_pkg::ST_BAD_PAD;
        end

        // end-of-frame checks
        if ((st == ftr_pkg::ST_OK) && (({1'b0, item.word_position} + 9'd1) == n_c)) begin
          expected_nxt = expected_r + 16'd1;
          if (in_start && ((size_nxt > ftr_pkg::SIZE_LIMIT) || (size_nxt[1:0] != 2'd0))) begin
            st = ftr_pkg::ST_BAD_LENGTH;
          end else if ({17'd0, wi_nxt} == size_nxt[31:1]) begin
            if (!item.stop_flag) begin
              st = ftr_pkg::ST_NO_STOP;
            end else begin
              done_nxt = 1'b1;
              st       = ftr_pkg::ST_COMPLETED;
            end
          end else if (item.stop_flag) begin
            st = ftr_pkg::ST_EARLY_STOP;
          end
        end
      end

      if ((st >= ftr_pkg::ST_SECOND_START) && (st <= ftr_pkg::ST_EARLY_STOP)) begin
        err_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r       <= '0;
      size_r     <= '0;
      latched_r  <= '0;
      expected_r <= '0;
      done_r     <= 1'b0;
      err_r      <= 1'b0;
      skip_r     <= 1'b0;
      allowed_r  <= '0;
    end else if (advance) begin
      wi_r       <= wi_nxt;
      size_r     <= size_nxt;
      latched_r  <= latched_nxt;
      expected_r <= expected_nxt;
      done_r     <= done_nxt;
      err_r      <= err_nxt;
      skip_r     <= skip_nxt;
      allowed_r  <= allowed_nxt;
    end
  end

  assign result.write_valid       = wv;
  assign result.write_address     = wa;
  assign result.write_data        = wd;
  assign result.status            = st;
  assign result.transaction_bytes = size_nxt;

  assign flags.error = err_r;
  assign flags.done  = done_r;

endmodule
`default_nettype wire

[design/frame_transaction_reassembler_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// frame_transaction_reassembler_top: frame transaction reassembler
// Rebuilds one transaction from frame payload words, one result per beat.
//
//   channel   direction  beat contents
//   in_chan   in         payload word with its frame header fields
//   out_chan  out        buffer write, status, latched byte size
//
// one beat per cycle sustained while the result is taken; each beat passes
// the input register and the result register around the check logic
// rst_n clears the transaction state and both stage valids
// a stalled result holds; a new beat is still taken while the input stage
// is free or drains into the result register in the same cycle
// ----------------------------------------------------------------------------
module frame_transaction_reassembler_top (
  input  wire logic clk,
  input  wire logic rst_n,
  ftr_in_if.sink    in_chan,
  ftr_out_if.source out_chan
);

  logic              in_valid_r;
  ftr_pkg::item_t    in_item_r;
  logic              out_valid_r;
  ftr_pkg::result_t  out_r;
  logic              move;
  ftr_pkg::result_t  result;
  ftr_pkg::flags_t   flags;

  assign move          = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_item_r.operation         <= in_chan.operation;
      in_item_r.payload_word      <= in_chan.payload_word;
      in_item_r.word_position     <= in_chan.word_position;
      in_item_r.frame_word_count  <= in_chan.frame_word_count;
      in_item_r.start_flag        <= in_chan.start_flag;
      in_item_r.stop_flag         <= in_chan.stop_flag;
      in_item_r.frame_transaction <= in_chan.frame_transaction;
      in_item_r.frame_sequence    <= in_chan.frame_sequence;
    end
  end

  ftr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (move),
    .item    (in_item_r),
    .result  (result),
    .flags   (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      out_valid_r <= move;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_r <= result;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.write_valid       = out_r.write_valid;
  assign out_chan.write_address     = out_r.write_address;
  assign out_chan.write_data        = out_r.write_data;
  assign out_chan.status            = 4'(out_r.status);
  assign out_chan.transaction_bytes = out_r.transaction_bytes;

`ifndef SYNTHESIS
  a_ready_when_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_chan.ready) |-> in_chan.ready)
    else $error("input stage not ready although result stage drains");

  a_no_write_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.write_valid) |->
      (out_r.write_address == '0 && out_r.write_data == '0))
    else $error("write fields not zero on a beat without a write");

  a_sticky_error: assert property (@(posedge clk) disable iff (!rst_n)
    (move && flags.error && !in_item_r.operation) |=>
      (out_r.status == ftr_pkg::ST_IN_ERROR && !out_r.write_valid))
    else $error("beat in error state not answered with in-error status");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (flags.done && !(move && in_item_r.operation)) |=> flags.done)
    else $error("completion flag dropped without a reset beat");
`endif

endmodule
`default_nettype wire
